// ===== hdl/imu_uart_frame_parser_core_assert.svh =====
// Assertion macros shared by the checker of the frame parser.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef IMU_UART_FRAME_PARSER_CORE_ASSERT_SVH
`define IMU_UART_FRAME_PARSER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define IMUFP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("imufp: assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define IMUFP_ASSERT_NEXT(lbl, ante, cons) \
    `IMUFP_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hdl/imufp_pkg.sv =====
// Shared types and constants of the serial IMU frame parser.
// Used by imufp_frame_fsm, the top level and the checker.
package imufp_pkg;

    localparam logic [7:0] FRAME_HEADER   = 8'h55;
    localparam int         FRAME_LENGTH   = 11;
    localparam int         POS_W          = 4;
    localparam int         PAY_DEPTH      = 8;
    localparam int         PAY_IDX_W      = $clog2(PAY_DEPTH);

    localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(FRAME_LENGTH - 1);

    // Configuration register indexes and reset values
    localparam int         CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CODE = 2'd2;
    localparam logic [7:0] ACCEL_CODE_RST = 8'h51;
    localparam logic [7:0] GYRO_CODE_RST  = 8'h52;
    localparam logic [7:0] ANGLE_CODE_RST = 8'h53;

    // Frame kinds as reported on the result channel
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE   = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         kind;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
        logic signed [15:0] temperature_raw;
    } frame_res_t;

endpackage

// ===== hdl/imu_uart_frame_parser_core.sv =====
// Top level of the serial IMU frame parser: handshakes, type codes, result register.
// Depends on imufp_pkg and imufp_frame_fsm.
//
// Usage:
//   s_ channel: one received byte per item (s_rx_byte), valid/ready.
//   m_ channel: one decoded frame per item: kind, three signed raw values and
//   temperature (zero unless the frame is an acceleration frame).
//   cfg_ port: write cfg_data to type code cfg_index while cfg_we is high;
//   index 0 accel, 1 gyro, 2 angle, index 3 is ignored. Write only when idle.
// Result: registered; the result of a frame appears on m_ in the cycle after
//   its checksum byte is accepted.
// Throughput: one byte per cycle, set by the per-byte update of the frame
//   tracker; the result register lets the next byte in while a result is
//   taken, and s_ready drops only while a result is held and m_ready is low.
// Reset: synchronous, active low; type codes return to 0x51/0x52/0x53, the
//   tracker goes back to hunting for the header, and no result is pending.
// Stall: while m_ready is low with a result held, s_ready is low and the
//   result holds unchanged; bad frames never reach the m_ channel.
module imu_uart_frame_parser_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // byte input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    // frame output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_frame_kind,
    output logic signed [15:0]               m_value_x,
    output logic signed [15:0]               m_value_y,
    output logic signed [15:0]               m_value_z,
    output logic signed [15:0]               m_temperature_raw,
    // configuration
    input  logic                             cfg_we,
    input  logic [imufp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);
    import imufp_pkg::*;

    logic [7:0] accel_reg, gyro_reg, angle_reg;
    logic       m_valid_reg;
    logic       s_accept;
    frame_res_t res;
    frame_res_t out_reg;

    // Accept a byte whenever the result register is free or is being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Type code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg <= ACCEL_CODE_RST;
            gyro_reg  <= GYRO_CODE_RST;
            angle_reg <= ANGLE_CODE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACCEL_CODE: accel_reg <= cfg_data;
                CFG_GYRO_CODE:  gyro_reg  <= cfg_data;
                CFG_ANGLE_CODE: angle_reg <= cfg_data;
                default:        ; // drop writes to unknown indexes
            endcase
        end
    end

    imufp_frame_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_accept),
        .rx_byte    (s_rx_byte),
        .accel_code (accel_reg),
        .gyro_code  (gyro_reg),
        .angle_code (angle_reg),
        .res        (res)
    );

    // Result valid: set on a good frame, clear once the item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && res.hit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload: load only on a good frame, otherwise hold
    always_ff @(posedge aclk) begin
        if (s_accept && res.hit) begin
            out_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_frame_kind      = out_reg.kind;
    assign m_value_x         = out_reg.value_x;
    assign m_value_y         = out_reg.value_y;
    assign m_value_z         = out_reg.value_z;
    assign m_temperature_raw = out_reg.temperature_raw;

endmodule

// ===== hdl/imufp_frame_fsm.sv =====
// Frame tracker: header hunt, byte position, running sum and payload capture.
// Depends on imufp_pkg; produces the decoded result for the current byte.
module imufp_frame_fsm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            accel_code,
    input  logic [7:0]            gyro_code,
    input  logic [7:0]            angle_code,
    output imufp_pkg::frame_res_t res
);
    import imufp_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       pay_reg [PAY_DEPTH];
    logic             pay_we;
    logic [PAY_IDX_W-1:0] pay_idx;
    logic             at_checksum;
    logic             sum_ok;

    assign at_checksum = (phase_reg == PH_DATA) && (pos_reg == POS_CHECKSUM);
    assign sum_ok      = (sum_reg == rx_byte);
    assign pay_idx     = PAY_IDX_W'(pos_reg - POS_FIRST_DATA);

    // Next-state logic
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        pay_we     = 1'b0;
        if (step) begin
            case (phase_reg)
                PH_TYPE: begin
                    type_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    pos_next   = POS_FIRST_DATA;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    if (pos_reg < POS_CHECKSUM) begin
                        pay_we   = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + POS_W'(1);
                    end else begin
                        pos_next   = '0;
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    // Hunt for the header; the unused code behaves the same
                    if (rx_byte == FRAME_HEADER) begin
                        sum_next   = FRAME_HEADER;
                        pos_next   = POS_TYPE;
                        phase_next = PH_TYPE;
                    end
                end
            endcase
        end
    end

    // Output logic: decode on the checksum byte
    always_comb begin
        res = '0;
        res.value_x = {pay_reg[1], pay_reg[0]};
        res.value_y = {pay_reg[3], pay_reg[2]};
        res.value_z = {pay_reg[5], pay_reg[4]};
        if (type_reg == accel_code) begin
            res.kind            = KIND_ACCEL;
            res.hit             = at_checksum && sum_ok;
            res.temperature_raw = {pay_reg[7], pay_reg[6]};
        end else if (type_reg == gyro_code) begin
            res.kind = KIND_GYRO;
            res.hit  = at_checksum && sum_ok;
        end else if (type_reg == angle_code) begin
            res.kind = KIND_ANGLE;
            res.hit  = at_checksum && sum_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            sum_reg   <= '0;
            type_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pay_we) begin
            pay_reg[pay_idx] <= rx_byte;
        end
    end

endmodule

// ===== hdl/imufp_checker.sv =====
// Port-level checker for the frame parser, bound to the top level.
// Depends on imufp_pkg and imu_uart_frame_parser_core_assert.svh.
`include "imu_uart_frame_parser_core_assert.svh"

module imufp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_frame_kind,
    input logic signed [15:0] m_value_x,
    input logic signed [15:0] m_temperature_raw
);
    import imufp_pkg::*;

    // A held result stays offered and its value_x stays unchanged
    `IMUFP_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid)
    `IMUFP_ASSERT_NEXT(a_hold_data, m_valid && !m_ready, $stable(m_value_x))
    // Kind is one of the three frame kinds
    `IMUFP_ASSERT(a_kind_legal, m_valid |-> (m_frame_kind <= KIND_ANGLE))
    // Temperature is carried only by acceleration frames
    `IMUFP_ASSERT(a_temp_zero, (m_valid && m_frame_kind != KIND_ACCEL) |-> (m_temperature_raw == '0))
    // A new result needs an accepted byte in the cycle before
    `IMUFP_ASSERT(a_result_cause, $rose(m_valid) |-> $past(s_valid && s_ready))

endmodule

bind imu_uart_frame_parser_core imufp_checker u_imufp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_frame_kind      (m_frame_kind),
    .m_value_x         (m_value_x),
    .m_temperature_raw (m_temperature_raw)
);

// ===== bench/imufp_frame_checker.sv =====
// Frame checker for the serial IMU frame parser: follows the byte stream and the
// type-code writes, predicts each decoded frame and compares the m_ channel with it.
// Depends on imufp_pkg.
module imufp_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_frame_kind,
    input  logic signed [15:0]              m_value_x,
    input  logic signed [15:0]              m_value_y,
    input  logic signed [15:0]              m_value_z,
    input  logic signed [15:0]              m_temperature_raw,
    input  logic                            cfg_we,
    input  logic [imufp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            drain_done,
    output int                              frames_pending,
    output int                              mismatches
);
    import imufp_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] temp;
    } decoded_frame_t;

    decoded_frame_t frames_due[$];

    logic [7:0] code_accel, code_gyro, code_angle;
    phase_t     track_phase;
    logic [3:0] track_pos;
    logic [7:0] track_sum;
    logic [7:0] track_type;
    logic [7:0] track_payload [PAY_DEPTH];
    bit         leftover_checked;

    initial begin
        mismatches = 0;
        frames_pending = 0;
        leftover_checked = 0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] frame check: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the frame tracker by one byte; queue a decoded frame on a good frame.
    task automatic absorb_byte(input logic [7:0] b);
        decoded_frame_t f;
        bit             hit;
        hit = 1'b1;
        case (track_phase)
            PH_TYPE: begin
                track_type  = b;
                track_sum   = track_sum + b;
                track_pos   = POS_FIRST_DATA;
                track_phase = PH_DATA;
            end
            PH_DATA: begin
                if (track_pos < POS_CHECKSUM) begin
                    track_payload[3'(track_pos - POS_FIRST_DATA)] = b;
                    track_sum = track_sum + b;
                    track_pos = track_pos + 4'd1;
                end else begin
                    track_phase = PH_HEADER;
                    track_pos   = '0;
                    if (track_sum == b) begin
                        if (track_type == code_accel)      f.kind = KIND_ACCEL;
                        else if (track_type == code_gyro)  f.kind = KIND_GYRO;
                        else if (track_type == code_angle) f.kind = KIND_ANGLE;
                        else hit = 1'b0;
                        if (hit) begin
                            f.x    = {track_payload[1], track_payload[0]};
                            f.y    = {track_payload[3], track_payload[2]};
                            f.z    = {track_payload[5], track_payload[4]};
                            f.temp = (f.kind == KIND_ACCEL) ?
                                     {track_payload[7], track_payload[6]} : 16'h0000;
                            frames_due.push_back(f);
                        end
                    end
                end
            end
            default: begin
                if (b == FRAME_HEADER) begin
                    track_sum   = FRAME_HEADER;
                    track_pos   = POS_TYPE;
                    track_phase = PH_TYPE;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        decoded_frame_t want;
        if (!aresetn) begin
            code_accel  = ACCEL_CODE_RST;
            code_gyro   = GYRO_CODE_RST;
            code_angle  = ANGLE_CODE_RST;
            track_phase = PH_HEADER;
            track_pos   = '0;
            track_sum   = '0;
            track_type  = '0;
            frames_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    flag_mismatch("unexpected frame, kind", m_frame_kind, -1);
                end else begin
                    want = frames_due.pop_front();
                    if (m_frame_kind !== want.kind)
                        flag_mismatch("frame_kind", m_frame_kind, want.kind);
                    if (m_value_x !== want.x)
                        flag_mismatch("value_x", m_value_x, $signed(want.x));
                    if (m_value_y !== want.y)
                        flag_mismatch("value_y", m_value_y, $signed(want.y));
                    if (m_value_z !== want.z)
                        flag_mismatch("value_z", m_value_z, $signed(want.z));
                    if (m_temperature_raw !== want.temp)
                        flag_mismatch("temperature_raw", m_temperature_raw,
                                      $signed(want.temp));
                end
            end
            if (s_valid && s_ready)
                absorb_byte(s_rx_byte);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACCEL_CODE: code_accel = cfg_data;
                    CFG_GYRO_CODE:  code_gyro  = cfg_data;
                    CFG_ANGLE_CODE: code_angle = cfg_data;
                    default: ;
                endcase
            end
            if (drain_done && !leftover_checked) begin
                leftover_checked = 1;
                if (frames_due.size() != 0)
                    flag_mismatch("frames never delivered", 0, frames_due.size());
            end
        end
        frames_pending = frames_due.size();
    end

endmodule

// ===== bench/tb_imu_uart_frame_parser_core.sv =====
// Testbench top for the serial IMU frame parser: clock, reset, byte stimulus,
// type-code writes, result back-pressure and the verdict.
// Depends on imufp_pkg, imu_uart_frame_parser_core and imufp_frame_checker.
module tb_imu_uart_frame_parser_core;
    import imufp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 950;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_frame_kind;
    logic signed [15:0]   m_value_x, m_value_y, m_value_z, m_temperature_raw;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ACCEL_CODE;
    logic [7:0]           cfg_data = 8'h00;
    logic                 drain_done = 1'b0;

    int frames_pending;
    int mismatches;

    // Idle rates in percent, changed per phase by the main sequence
    int sender_idle_pct = 0;
    int stall_pct = 0;
    // Long hold-off requests: the receiver serves one per increment
    int holds_asked = 0;
    int holds_served = 0;
    int bytes_sent = 0;
    int cycles = 0;

    // Copies of the type codes, used only to shape the stimulus
    logic [7:0] code_accel = ACCEL_CODE_RST;
    logic [7:0] code_gyro  = GYRO_CODE_RST;
    logic [7:0] code_angle = ANGLE_CODE_RST;

    imu_uart_frame_parser_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_kind      (m_frame_kind),
        .m_value_x         (m_value_x),
        .m_value_y         (m_value_y),
        .m_value_z         (m_value_z),
        .m_temperature_raw (m_temperature_raw),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    imufp_frame_checker u_frame_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_kind      (m_frame_kind),
        .m_value_x         (m_value_x),
        .m_value_y         (m_value_y),
        .m_value_z         (m_value_z),
        .m_temperature_raw (m_temperature_raw),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .drain_done        (drain_done),
        .frames_pending    (frames_pending),
        .mismatches        (mismatches)
    );

    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // Watchdog: end the run if the handshakes ever hang.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: stall at random, or hold m_ready low for a long stretch when asked.
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_served != holds_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                holds_served++;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one byte, after a random idle gap, and hold it until accepted.
    // Valid stays high after acceptance so back-to-back items need no re-raise.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 8)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send header, type, eight data bytes and the checksum; corrupt the sum on request.
    task automatic send_frame(input logic [7:0] type_byte, input logic [63:0] data,
                              input bit corrupt);
        logic [7:0] sum;
        sum = FRAME_HEADER + type_byte;
        put_byte(FRAME_HEADER);
        put_byte(type_byte);
        for (int i = 0; i < 8; i++) begin
            put_byte(data[8*i +: 8]);
            sum = sum + data[8*i +: 8];
        end
        put_byte(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
    endtask

    // Data byte biased toward the edges of the signed range and the header value.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            4: return FRAME_HEADER;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One random frame, mostly well formed; sometimes preceded by noise or cut short.
    task automatic send_random_frame();
        logic [63:0] data;
        logic [7:0]  type_byte;
        int          r;
        for (int i = 0; i < 8; i++)
            data[8*i +: 8] = pick_byte();
        r = $urandom_range(9);
        if (r < 3)      type_byte = code_accel;
        else if (r < 6) type_byte = code_gyro;
        else if (r < 8) type_byte = code_angle;
        else            type_byte = 8'($urandom_range(255));
        // Line noise between frames; a stray header starts a frame of its own.
        if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
        // Truncated frame: the next frame's bytes get swallowed as its tail.
        if ($urandom_range(99) < 5) begin
            put_byte(FRAME_HEADER);
            repeat ($urandom_range(1, 9)) put_byte(pick_byte());
        end
        send_frame(type_byte, data, $urandom_range(99) < 15);
    endtask

    // Drop valid and wait until every expected frame has come out, plus a margin.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frames_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write all three type codes and the unused index, one write per cycle.
    task automatic set_codes(input logic [7:0] a, input logic [7:0] g, input logic [7:0] n);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACCEL_CODE;
        cfg_data  <= a;
        @(negedge aclk);
        cfg_index <= CFG_GYRO_CODE;
        cfg_data  <= g;
        @(negedge aclk);
        cfg_index <= CFG_ANGLE_CODE;
        cfg_data  <= n;
        @(negedge aclk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'($urandom_range(255));
        @(negedge aclk);
        cfg_we    <= 1'b0;
        code_accel = a;
        code_gyro  = g;
        code_angle = n;
    endtask

    task automatic random_phase(input int idle, input int stall, input int items);
        int stop_at;
        sender_idle_pct = idle;
        stall_pct       = stall;
        stop_at         = bytes_sent + items;
        while (bytes_sent < stop_at)
            send_random_frame();
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: stray bytes while hunting, then one frame of each kind at
        // the reset codes, the acceleration frame with the extremes of the signed
        // range. The angular rate frame carries header bytes as data and a
        // temperature that must come out as zero.
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(ACCEL_CODE_RST, 64'h0000_FFFF_7FFF_8000, 1'b0);
        send_frame(GYRO_CODE_RST,  64'h1234_FF00_0001_5555, 1'b0);
        send_frame(ANGLE_CODE_RST, 64'h8001_7F80_0000_FFFE, 1'b0);
        drain();

        // Extreme codes, no idling.
        set_codes(8'h00, 8'hFF, 8'h7F);
        random_phase(0, 0, RANDOM_ITEMS / 4);

        // Codes equal to each other and to the header byte; accel wins the tie.
        set_codes(FRAME_HEADER, FRAME_HEADER, 8'h00);
        random_phase(50, 0, RANDOM_ITEMS / 4);

        // Long hold-off on the result side while the sender keeps going at
        // full rate, so the held result backs up into s_ready.
        sender_idle_pct = 0;
        holds_asked++;
        repeat (4) send_frame(code_accel, {$urandom, $urandom}, 1'b0);
        drain();

        // Random codes with the receiver stalling.
        set_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        random_phase(0, 50, RANDOM_ITEMS / 4);

        // Back to the usual codes with both sides idling.
        set_codes(ACCEL_CODE_RST, GYRO_CODE_RST, ANGLE_CODE_RST);
        random_phase(23, 23, RANDOM_ITEMS / 4);

        @(negedge aclk);
        drain_done <= 1'b1;
        repeat (2) @(negedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
